FILE: rtl/ccm_pkg.sv
package ccm_pkg;

  // Input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_AAD   = 2'd1;
  localparam logic [1:0] MODE_PAY   = 2'd2;
  localparam logic [1:0] MODE_TAG   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_PAY  = 2'd0;
  localparam logic [1:0] KIND_TAG  = 2'd1;
  localparam logic [1:0] KIND_PASS = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_TAG_LEN  = 2'd2;
  localparam logic [1:0] REG_DIR      = 2'd3;

  localparam int          LENGTH_FIELD_OCTETS = 2;
  localparam logic [15:0] LONG_AAD_MIN        = 16'hFF00;
  localparam logic [3:0]  LAST_ROUND          = 4'd10;
  localparam logic [4:0]  BLOCK_BYTES         = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_B0, ST_A0, ST_KS, ST_PAY, ST_SETTLE, ST_ABS, ST_TAGOUT, ST_VERDICT
  } ccm_state_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_AAD, PH_PAYLOAD, PH_TAG
  } ccm_phase_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    case (rnd)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  // Next round key from the current one
  function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] temp;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    temp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ temp;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    key_expand = {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and, except in the last round, MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
    logic [7:0] t [16];
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;
    logic [7:0] x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[s[127-8*((((c+i)%4)*4)+i) -: 8]];
      end
    end
    if (!last_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    aes_round = r;
  endfunction

  // Tag size: clamp to 4..16, round down to even
  function automatic logic [4:0] eff_tag(input logic [4:0] tl);
    logic [4:0] m;
    m = tl;
    if (m < 5'd4) m = 5'd4;
    if (m > 5'd16) m = 5'd16;
    eff_tag = {m[4:1], 1'b0};
  endfunction

endpackage

FILE: rtl/ccm_if.sv
interface ccm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic [39:0] nonce_high;
  logic [63:0] nonce_low;
  logic [15:0] aad_length;
  logic [15:0] payload_length;
  modport source (output valid, mode, data_byte, nonce_high, nonce_low, aad_length,
                  payload_length, input ready);
  modport sink (input valid, mode, data_byte, nonce_high, nonce_low, aad_length,
                payload_length, output ready);
endinterface

interface ccm_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte_res;
  logic       last;
  modport source (output valid, kind, data_byte_res, last, input ready);
  modport sink (input valid, kind, data_byte_res, last, output ready);
endinterface

interface ccm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/aes_ccm_auth_encrypt_decrypt.sv
// Channel  Role     Payload
// item     sink     mode, data_byte, nonce_high, nonce_low, aad_length, payload_length
// result   source   kind, data_byte_res, last
// cfg      sink     index, data (write only, always ready)
//
// A start item runs B0 and the counter-zero block through the round unit.
// A payload byte that opens a block, a byte that fills a MAC block, and the tail of each
// section cost one more AES pass; other associated data bytes, other payload bytes, tag
// bytes and ignored items need no AES pass.
// The single iterative AES round unit serves all of these passes; item.ready is high only when idle.
// Tag emission takes one cycle per byte while result.ready stays high.
// Reset (rst, synchronous) returns to idle with key zero, tag_length 4 and encrypt.
module aes_ccm_auth_encrypt_decrypt
  import ccm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  ccm_item_if.sink  item,
  ccm_res_if.source result,
  ccm_cfg_if.sink   cfg
);

  ccm_state_t state, state_next;
  ccm_phase_t phase;

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic [4:0]   tag_length;
  logic         direction;

  logic [127:0] mac_chain;
  logic [127:0] mac_buf;
  logic [127:0] keystream;
  logic [127:0] ctr;
  logic [127:0] tag_mask;
  logic [127:0] rx_tag;
  logic [4:0]   byte_pos;
  logic [15:0]  remaining;
  logic [15:0]  pending;
  logic [7:0]   d_hold;
  logic [4:0]   tag_idx;

  logic         aes_start;
  logic [127:0] aes_block;
  logic         aes_busy;
  logic         aes_done;
  logic [127:0] aes_res;

  logic         acc;
  logic         aad_ok;
  logic         pay_ok;
  logic         tag_ok;
  logic         out_free;
  logic         out_load;
  logic [1:0]   load_kind;
  logic [7:0]   load_data;
  logic         load_last;
  logic [4:0]   m;
  logic [127:0] b0;
  logic [127:0] ctr_inc;
  logic [7:0]   pay_res;
  logic [7:0]   plain;
  logic [127:0] tag_diff;
  logic         tag_bad;
  logic         absorb_now;
  logic [7:0]   tag_byte;

  ccm_aes_core u_aes (
    .clk       (clk),
    .rst       (rst),
    .start     (aes_start),
    .block_in  (aes_block),
    .key       ({key_high, key_low}),
    .busy      (aes_busy),
    .done      (aes_done),
    .block_out (aes_res)
  );

  // Configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= 64'd0;
      key_low    <= 64'd0;
      tag_length <= 5'd4;
      direction  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_HIGH: key_high   <= cfg.data;
        REG_KEY_LOW:  key_low    <= cfg.data;
        REG_TAG_LEN:  tag_length <= cfg.data[4:0];
        REG_DIR:      direction  <= cfg.data[0];
        default:      ;
      endcase
    end
  end

  // Decode and shared datapath terms
  always_comb begin
    acc      = item.valid && item.ready;
    aad_ok   = (item.mode == MODE_AAD) && (phase == PH_AAD) && (remaining != 16'd0);
    pay_ok   = (item.mode == MODE_PAY) && (phase == PH_PAYLOAD) && (remaining != 16'd0);
    tag_ok   = (item.mode == MODE_TAG) && (phase == PH_TAG) && (remaining != 16'd0);
    out_free = !result.valid || result.ready;
    m        = eff_tag(tag_length);
    b0       = {1'b0, (item.aad_length != 16'd0), 3'((m - 5'd2) >> 1),
                3'(LENGTH_FIELD_OCTETS - 1), item.nonce_high, item.nonce_low,
                item.payload_length};
    ctr_inc  = {ctr[127:16], ctr[15:0] + 16'd1};
    pay_res  = d_hold ^ keystream[127-8*byte_pos[3:0] -: 8];
    plain    = direction ? pay_res : d_hold;
    tag_diff = rx_tag ^ mac_chain ^ tag_mask;
    tag_bad  = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < m) tag_bad = tag_bad | (|tag_diff[127-8*i -: 8]);
    end
    tag_byte   = mac_chain[127-8*tag_idx[3:0] -: 8] ^ tag_mask[127-8*tag_idx[3:0] -: 8];
    absorb_now = (byte_pos == BLOCK_BYTES) ||
                 (((phase == PH_AAD) || (phase == PH_PAYLOAD)) && (remaining == 16'd0) &&
                  (byte_pos != 5'd0));
  end

  assign item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequencer: next state, AES launch, result load
  always_comb begin
    state_next = state;
    aes_start  = 1'b0;
    aes_block  = mac_chain ^ mac_buf;
    out_load   = 1'b0;
    load_kind  = KIND_PAY;
    load_data  = 8'd0;
    load_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (item.mode)
            MODE_START: begin
              aes_start  = 1'b1;
              aes_block  = b0;
              state_next = ST_B0;
            end
            MODE_AAD: begin
              if (aad_ok) state_next = ST_SETTLE;
            end
            MODE_PAY: begin
              if (pay_ok) begin
                if (byte_pos == 5'd0) begin
                  aes_start  = 1'b1;
                  aes_block  = ctr_inc;
                  state_next = ST_KS;
                end else begin
                  state_next = ST_PAY;
                end
              end
            end
            MODE_TAG: begin
              if (tag_ok && remaining == 16'd1) state_next = ST_VERDICT;
            end
            default: ;
          endcase
        end
      end
      ST_B0: begin
        if (aes_done) begin
          aes_start  = 1'b1;
          aes_block  = ctr;
          state_next = ST_A0;
        end
      end
      ST_A0: begin
        if (aes_done) state_next = ST_SETTLE;
      end
      ST_KS: begin
        if (aes_done) state_next = ST_PAY;
      end
      ST_PAY: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_kind  = KIND_PAY;
          load_data  = pay_res;
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (absorb_now) begin
          aes_start  = 1'b1;
          state_next = ST_ABS;
        end else if (phase == PH_AAD && remaining == 16'd0) begin
          state_next = ST_SETTLE;
        end else if (phase == PH_PAYLOAD && remaining == 16'd0 && !direction) begin
          state_next = ST_TAGOUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ABS: begin
        if (aes_done) state_next = ST_SETTLE;
      end
      ST_TAGOUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = KIND_TAG;
          load_data = tag_byte;
          load_last = (tag_idx + 5'd1 == m);
          if (load_last) state_next = ST_IDLE;
        end
      end
      ST_VERDICT: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_kind  = tag_bad ? KIND_FAIL : KIND_PASS;
          load_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Packet state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      byte_pos  <= 5'd0;
      remaining <= 16'd0;
      pending   <= 16'd0;
      tag_idx   <= 5'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            case (item.mode)
              MODE_START: begin
                ctr       <= {8'(LENGTH_FIELD_OCTETS - 1), item.nonce_high, item.nonce_low,
                              16'd0};
                rx_tag    <= 128'd0;
                keystream <= 128'd0;
                pending   <= item.payload_length;
                if (item.aad_length == 16'd0) begin
                  mac_buf   <= 128'd0;
                  byte_pos  <= 5'd0;
                  phase     <= PH_PAYLOAD;
                  remaining <= item.payload_length;
                end else begin
                  if (item.aad_length < LONG_AAD_MIN) begin
                    mac_buf  <= {item.aad_length, 112'd0};
                    byte_pos <= 5'd2;
                  end else begin
                    mac_buf  <= {16'hFFFE, 16'd0, item.aad_length, 80'd0};
                    byte_pos <= 5'd6;
                  end
                  phase     <= PH_AAD;
                  remaining <= item.aad_length;
                end
              end
              MODE_AAD: begin
                if (aad_ok) begin
                  mac_buf[127-8*byte_pos[3:0] -: 8] <= item.data_byte;
                  byte_pos  <= byte_pos + 5'd1;
                  remaining <= remaining - 16'd1;
                end
              end
              MODE_PAY: begin
                if (pay_ok) begin
                  d_hold <= item.data_byte;
                  if (byte_pos == 5'd0) ctr <= ctr_inc;
                end
              end
              MODE_TAG: begin
                if (tag_ok) begin
                  rx_tag[127-8*byte_pos[3:0] -: 8] <= item.data_byte;
                  remaining <= remaining - 16'd1;
                  if (remaining == 16'd1) begin
                    byte_pos <= 5'd0;
                    phase    <= PH_IDLE;
                  end else begin
                    byte_pos <= byte_pos + 5'd1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_B0: begin
          if (aes_done) mac_chain <= aes_res;
        end
        ST_A0: begin
          if (aes_done) tag_mask <= aes_res;
        end
        ST_KS: begin
          if (aes_done) keystream <= aes_res;
        end
        ST_PAY: begin
          if (out_free) begin
            mac_buf[127-8*byte_pos[3:0] -: 8] <= plain;
            byte_pos  <= byte_pos + 5'd1;
            remaining <= remaining - 16'd1;
          end
        end
        ST_SETTLE: begin
          if (!absorb_now) begin
            if (phase == PH_AAD && remaining == 16'd0) begin
              phase     <= PH_PAYLOAD;
              remaining <= pending;
            end else if (phase == PH_PAYLOAD && remaining == 16'd0) begin
              byte_pos <= 5'd0;
              if (!direction) begin
                tag_idx <= 5'd0;
              end else begin
                phase     <= PH_TAG;
                remaining <= 16'(m);
              end
            end
          end
        end
        ST_ABS: begin
          if (aes_done) begin
            mac_chain <= aes_res;
            mac_buf   <= 128'd0;
            byte_pos  <= 5'd0;
          end
        end
        ST_TAGOUT: begin
          if (out_free) begin
            tag_idx <= tag_idx + 5'd1;
            if (tag_idx + 5'd1 == m) phase <= PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid         <= 1'b1;
      result.kind          <= load_kind;
      result.data_byte_res <= load_data;
      result.last          <= load_last;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_aes_start_idle: assert property (@(posedge clk) disable iff (rst)
    aes_start |-> !aes_busy)
    else $error("AES unit restarted while busy");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= BLOCK_BYTES)
    else $error("byte position past block end");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last) |-> (result.kind != KIND_PAY))
    else $error("payload byte marked last");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result overwritten before transfer");
`endif

endmodule

FILE: rtl/ccm_aes_core.sv
module ccm_aes_core
  import ccm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] block_in,
  input  logic [127:0] key,
  output logic         busy,
  output logic         done,
  output logic [127:0] block_out
);

  logic [127:0] st;
  logic [127:0] rk;
  logic [3:0]   rnd;
  logic [127:0] rk_next;
  logic [127:0] st_next;

  // One round and one key expansion step per cycle while busy
  always_comb begin
    rk_next = key_expand(rk, rcon(rnd));
    st_next = aes_round(st, rnd == LAST_ROUND) ^ rk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        st   <= block_in ^ key;
        rk   <= key;
        rnd  <= 4'd1;
        busy <= 1'b1;
      end else if (busy) begin
        st  <= st_next;
        rk  <= rk_next;
        rnd <= rnd + 4'd1;
        if (rnd == LAST_ROUND) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign block_out = st;

endmodule
